/* design/rau_pkg.sv */
// rau_pkg: shared types and constants of the rational arithmetic unit
// no dependencies; imported by the interfaces, rational_arith_unit and its bench
package rau_pkg;

   localparam int CMD_WIDTH = 3;
   localparam int NUM_WIDTH = 34;
   localparam int DEN_WIDTH = 33;

   typedef logic [CMD_WIDTH-1:0] cmd_type;
   typedef logic [NUM_WIDTH-1:0] res_num_type;
   typedef logic [DEN_WIDTH-1:0] res_den_type;

   // operation codes; unused codes behave as negate
   localparam cmd_type CMD_ADD = 3'd0;
   localparam cmd_type CMD_SUB = 3'd1;
   localparam cmd_type CMD_MUL = 3'd2;
   localparam cmd_type CMD_DIV = 3'd3;
   localparam cmd_type CMD_NEG = 3'd4;

endpackage

/* design/rau_req_if.sv */
// rau_req_if: request channel of the rational arithmetic unit
// depends on rau_pkg for the command type
interface rau_req_if #(parameter int OPERAND_WIDTH = 16);
   import rau_pkg::*;

   logic                            valid;
   logic                            ready;
   cmd_type                         cmd;
   logic signed [OPERAND_WIDTH-1:0] a_num;
   logic signed [OPERAND_WIDTH-1:0] a_den;
   logic signed [OPERAND_WIDTH-1:0] b_num;
   logic signed [OPERAND_WIDTH-1:0] b_den;

   modport source (output valid, cmd, a_num, a_den, b_num, b_den, input ready);
   modport sink   (input valid, cmd, a_num, a_den, b_num, b_den, output ready);
endinterface

/* design/rau_rsp_if.sv */
// rau_rsp_if: response channel of the rational arithmetic unit
// depends on rau_pkg for the result widths
interface rau_rsp_if;
   import rau_pkg::*;

   logic               valid;
   logic               ready;
   logic signed [NUM_WIDTH-1:0] res_num;
   res_den_type        res_den;
   logic               zero_den;

   modport source (output valid, res_num, res_den, zero_den, input ready);
   modport sink   (input valid, res_num, res_den, zero_den, output ready);
endinterface

/* design/rau_gcd.sv */
// rau_gcd: iterative binary gcd, one shift or subtract step per cycle
// both operands must be nonzero at start; no package dependencies
module rau_gcd #(parameter int WIDTH = 32) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] u_start,
   input  logic [WIDTH-1:0] v_start,
   output logic             done,
   output logic [WIDTH-1:0] gcd
);
   localparam int KW = $clog2(WIDTH);

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_TWO  = 3'd1;
   localparam logic [2:0] PH_ODDU = 3'd2;
   localparam logic [2:0] PH_LOOP = 3'd3;
   localparam logic [2:0] PH_DONE = 3'd4;

   logic [2:0]       phase_ff, phase_in;
   logic [WIDTH-1:0] u_ff, u_in;
   logic [WIDTH-1:0] v_ff, v_in;
   logic [KW-1:0]    k_ff, k_in;
   logic [WIDTH:0]   diff;
   logic             u_gt_v;

   // shared subtractor: borrow tells the compare
   assign diff   = {1'b0, u_ff} - {1'b0, v_ff};
   assign u_gt_v = !diff[WIDTH] && (diff[WIDTH-1:0] != '0);

   always_comb begin
      phase_in = phase_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      k_in     = k_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               u_in     = u_start;
               v_in     = v_start;
               k_in     = '0;
               phase_in = PH_TWO;
            end
         end
         PH_TWO: begin
            if (!(u_ff[0] | v_ff[0])) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + KW'(1);
            end else begin
               phase_in = PH_ODDU;
            end
         end
         PH_ODDU: begin
            if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else begin
               phase_in = PH_LOOP;
            end
         end
         PH_LOOP: begin
            if (v_ff == '0) begin
               phase_in = PH_DONE;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (u_gt_v) begin
               // swap then subtract
               u_in = v_ff;
               v_in = diff[WIDTH-1:0];
            end else begin
               v_in = WIDTH'(-diff[WIDTH-1:0]);
            end
         end
         PH_DONE: begin
            phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      u_ff <= u_in;
      v_ff <= v_in;
      k_ff <= k_in;
   end

   assign done = (phase_ff == PH_DONE);
   assign gcd  = u_ff << k_ff;
endmodule

/* design/rau_div.sv */
// rau_div: restoring unsigned divider, one quotient bit per cycle
// divisor must be nonzero; no package dependencies
module rau_div #(parameter int WIDTH = 32) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient
);
   localparam int CW = $clog2(WIDTH);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quot_ff, quot_in;
   logic [WIDTH-1:0] dsr_ff, dsr_in;
   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   diff;

   assign trial = {rem_ff, quot_ff[WIDTH-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dsr_in  = dsr_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            cnt_in  = CW'(WIDTH - 1);
            rem_in  = '0;
            quot_in = dividend;
            dsr_in  = divisor;
         end
      end else begin
         if (!diff[WIDTH]) begin
            rem_in  = diff[WIDTH-1:0];
            quot_in = {quot_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in  = trial[WIDTH-1:0];
            quot_in = {quot_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dsr_ff  <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;
endmodule

/* design/rational_arith_unit.sv */
// rational_arith_unit: exact add, subtract, multiply, divide and negate of fractions
// depends on rau_pkg, rau_req_if, rau_rsp_if, rau_gcd and rau_div
//
// usage
//  - req_chan carries one command and two fractions a_num/a_den, b_num/b_den
//    (b is ignored for negate); a transfer happens when valid and ready are high
//  - rsp_chan returns one reduced fraction per request: res_num carries the sign,
//    res_den is positive, zero is written as 0/1, a zero denominator gives 0/0
//    with zero_den set
//  - one request is worked on at a time: ready is high only while the sequencer
//    is idle. per request: capture, three products on the shared multiplier,
//    sum, check, then the binary gcd (one step a cycle), then two restoring
//    divisions by the gcd and the load into the output register; a zero or
//    error result skips the gcd and the divisions
//  - the result sits in an output register: the next request is taken while it
//    waits; if the receiver stalls with a result still held, the finished
//    result waits in the sequencer until the register frees
//  - reset (synchronous) returns the sequencer to idle and drops rsp valid
module rational_arith_unit #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   rau_req_if.sink   req_chan,
   rau_rsp_if.source rsp_chan
);
   import rau_pkg::*;

   localparam int W  = OPERAND_WIDTH;
   localparam int MW = 2 * OPERAND_WIDTH;              // magnitude of products and sums
   localparam int EW = (MW + 1 > NUM_WIDTH) ? MW + 1 : NUM_WIDTH;

   // sequencer states
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_MUL    = 4'd1;
   localparam logic [3:0] ST_SUM    = 4'd2;
   localparam logic [3:0] ST_CHECK  = 4'd3;
   localparam logic [3:0] ST_GCD    = 4'd4;
   localparam logic [3:0] ST_DIVN   = 4'd5;
   localparam logic [3:0] ST_WAITN  = 4'd6;
   localparam logic [3:0] ST_DIVD   = 4'd7;
   localparam logic [3:0] ST_WAITD  = 4'd8;
   localparam logic [3:0] ST_OUT    = 4'd9;

   localparam logic [1:0] STEP_FIRST = 2'd0;
   localparam logic [1:0] STEP_CROSS = 2'd1;
   localparam logic [1:0] STEP_DEN   = 2'd2;

   logic [3:0]    state_ff, state_in;
   logic [1:0]    step_ff, step_in;
   cmd_type       cmd_ff;

   // operands in sign and magnitude form
   logic [W-1:0]  an_mag_ff, ad_mag_ff, bn_mag_ff, bd_mag_ff;
   logic          an_sgn_ff, ad_sgn_ff, bn_sgn_ff, bd_sgn_ff;

   // products and reduced values
   logic [MW-1:0] t1_mag_ff, t2_mag_ff, d_mag_ff, n_mag_ff;
   logic          t1_sgn_ff, t2_sgn_ff, d_sgn_ff, n_sgn_ff;
   logic [MW-1:0] g_ff, nq_ff, dq_ff;
   logic          err_ff, zero_ff;

   // output register
   logic          rsp_valid_ff;
   res_num_type   res_num_ff, res_num_in;
   res_den_type   res_den_ff, res_den_in;
   logic          zero_den_ff, zero_den_in;

   logic          accept;
   logic          out_load;

   // shared multiplier
   logic [W-1:0]  mul_x, mul_y;
   logic          mul_sx, mul_sy;
   logic [MW-1:0] product;

   // sign-magnitude adder for the numerator
   logic [MW-1:0] sum_mag;
   logic          sum_sgn;

   // unit handshakes
   logic          gcd_start, gcd_done;
   logic [MW-1:0] gcd_val;
   logic          div_start, div_done;
   logic [MW-1:0] div_dividend, div_quot;

   // result formatting
   logic [EW-1:0] num_ext, num_signed, den_ext;

   function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
      mag_of = v[W-1] ? W'(~v + W'(1)) : v;
   endfunction

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = (state_ff == ST_IDLE);

   // operand pairs for the three products, by step and command
   always_comb begin
      mul_x  = an_mag_ff;
      mul_sx = an_sgn_ff;
      mul_y  = bd_mag_ff;
      mul_sy = bd_sgn_ff;
      case (step_ff)
         STEP_FIRST: begin
            mul_x  = an_mag_ff;
            mul_sx = an_sgn_ff;
            if (cmd_ff == CMD_MUL) begin
               mul_y  = bn_mag_ff;
               mul_sy = bn_sgn_ff;
            end else if (cmd_ff inside {CMD_ADD, CMD_SUB, CMD_DIV}) begin
               mul_y  = bd_mag_ff;
               mul_sy = bd_sgn_ff;
            end else begin
               // negate: times minus one
               mul_y  = W'(1);
               mul_sy = 1'b1;
            end
         end
         STEP_CROSS: begin
            mul_x  = ad_mag_ff;
            mul_sx = ad_sgn_ff;
            if (cmd_ff inside {CMD_ADD, CMD_SUB}) begin
               mul_y  = bn_mag_ff;
               mul_sy = bn_sgn_ff ^ (cmd_ff == CMD_SUB);
            end else begin
               mul_y  = '0;
               mul_sy = 1'b0;
            end
         end
         default: begin
            mul_x  = ad_mag_ff;
            mul_sx = ad_sgn_ff;
            if (cmd_ff inside {CMD_ADD, CMD_SUB, CMD_MUL}) begin
               mul_y  = bd_mag_ff;
               mul_sy = bd_sgn_ff;
            end else if (cmd_ff == CMD_DIV) begin
               mul_y  = bn_mag_ff;
               mul_sy = bn_sgn_ff;
            end else begin
               mul_y  = W'(1);
               mul_sy = 1'b0;
            end
         end
      endcase
   end

   assign product = MW'(mul_x) * MW'(mul_y);

   // signed magnitude sum, zero is never negative
   always_comb begin
      if (t1_sgn_ff == t2_sgn_ff) begin
         sum_mag = t1_mag_ff + t2_mag_ff;
         sum_sgn = t1_sgn_ff;
      end else if (t1_mag_ff >= t2_mag_ff) begin
         sum_mag = t1_mag_ff - t2_mag_ff;
         sum_sgn = t1_sgn_ff;
      end else begin
         sum_mag = t2_mag_ff - t1_mag_ff;
         sum_sgn = t2_sgn_ff;
      end
      if (sum_mag == '0) begin
         sum_sgn = 1'b0;
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      gcd_start = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MUL;
               step_in  = STEP_FIRST;
            end
         end
         ST_MUL: begin
            step_in = step_ff + 2'd1;
            if (step_ff == STEP_DEN) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (d_mag_ff == '0 || n_mag_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               gcd_start = 1'b1;
               state_in  = ST_GCD;
            end
         end
         ST_GCD: begin
            if (gcd_done) begin
               state_in = ST_DIVN;
            end
         end
         ST_DIVN: begin
            div_start = 1'b1;
            state_in  = ST_WAITN;
         end
         ST_WAITN: begin
            if (div_done) begin
               state_in = ST_DIVD;
            end
         end
         ST_DIVD: begin
            div_start = 1'b1;
            state_in  = ST_WAITD;
         end
         ST_WAITD: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign div_dividend = (state_ff == ST_DIVN) ? n_mag_ff : d_mag_ff;

   rau_gcd #(.WIDTH(MW)) u_gcd (
      .clock   (clock),
      .reset   (reset),
      .start   (gcd_start),
      .u_start (n_mag_ff),
      .v_start (d_mag_ff),
      .done    (gcd_done),
      .gcd     (gcd_val)
   );

   rau_div #(.WIDTH(MW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (g_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // result formatting: sign onto the numerator, special cases first
   assign num_ext    = EW'(nq_ff);
   assign num_signed = (n_sgn_ff != d_sgn_ff) ? EW'(-num_ext) : num_ext;
   assign den_ext    = EW'(dq_ff);

   always_comb begin
      if (err_ff) begin
         res_num_in  = '0;
         res_den_in  = '0;
         zero_den_in = 1'b1;
      end else if (zero_ff) begin
         res_num_in  = '0;
         res_den_in  = DEN_WIDTH'(1);
         zero_den_in = 1'b0;
      end else begin
         res_num_in  = num_signed[NUM_WIDTH-1:0];
         res_den_in  = den_ext[DEN_WIDTH-1:0];
         zero_den_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      // capture operands on the request transfer
      if (accept) begin
         cmd_ff    <= req_chan.cmd;
         an_mag_ff <= mag_of(req_chan.a_num);
         ad_mag_ff <= mag_of(req_chan.a_den);
         bn_mag_ff <= mag_of(req_chan.b_num);
         bd_mag_ff <= mag_of(req_chan.b_den);
         an_sgn_ff <= req_chan.a_num[W-1];
         ad_sgn_ff <= req_chan.a_den[W-1];
         bn_sgn_ff <= req_chan.b_num[W-1];
         bd_sgn_ff <= req_chan.b_den[W-1];
      end

      if (state_ff == ST_MUL) begin
         case (step_ff)
            STEP_FIRST: begin
               t1_mag_ff <= product;
               t1_sgn_ff <= mul_sx ^ mul_sy;
            end
            STEP_CROSS: begin
               t2_mag_ff <= product;
               t2_sgn_ff <= mul_sx ^ mul_sy;
            end
            default: begin
               d_mag_ff <= product;
               d_sgn_ff <= mul_sx ^ mul_sy;
            end
         endcase
      end

      if (state_ff == ST_SUM) begin
         n_mag_ff <= sum_mag;
         n_sgn_ff <= sum_sgn;
      end

      if (state_ff == ST_CHECK) begin
         err_ff  <= (d_mag_ff == '0);
         zero_ff <= (n_mag_ff == '0);
      end

      if (state_ff == ST_GCD && gcd_done) begin
         g_ff <= gcd_val;
      end
      if (state_ff == ST_WAITN && div_done) begin
         nq_ff <= div_quot;
      end
      if (state_ff == ST_WAITD && div_done) begin
         dq_ff <= div_quot;
      end

      if (out_load) begin
         res_num_ff  <= res_num_in;
         res_den_ff  <= res_den_in;
         zero_den_ff <= zero_den_in;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.res_num  = res_num_ff;
   assign rsp_chan.res_den  = res_den_ff;
   assign rsp_chan.zero_den = zero_den_ff;
endmodule

/* tb/sv/rational_arith_unit_test.sv */
// rational_arith_unit_test: self-checking bench for the rational arithmetic unit
// depends on rau_pkg, rau_req_if, rau_rsp_if and rational_arith_unit; a local
// predictor works out each reduced fraction and checks every response transfer
`timescale 1ns / 1ps

module rational_arith_unit_test;
   import rau_pkg::*;

   localparam int OPERAND_WIDTH = 16;
   localparam int DRAIN_CYCLES  = 200;   // a little over one worst-case request

   typedef logic signed [OPERAND_WIDTH-1:0] operand_type;

   // sign and magnitude, as the cross products are formed
   typedef struct {
      bit              neg;
      longint unsigned mag;
   } signed_mag_type;

   typedef struct packed {
      res_num_type num;
      res_den_type den;
      logic        zero_den;
   } fraction_result_type;

   logic clock;
   logic reset;

   int req_idle_pct;   // chance in a hundred that the sender idles a cycle
   int rsp_stall_pct;  // chance in a hundred that the receiver stalls a cycle
   int fail_count;

   fraction_result_type pending_results[$];

   rau_req_if #(.OPERAND_WIDTH(OPERAND_WIDTH)) req_bus();
   rau_rsp_if rsp_bus();

   rational_arith_unit #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   // two's complement field to sign and magnitude; zero is never negative
   function automatic signed_mag_type field_value(operand_type raw);
      signed_mag_type r;
      longint         v;
      v     = raw;
      r.neg = (v < 0);
      r.mag = r.neg ? -v : v;
      return r;
   endfunction

   function automatic signed_mag_type mul_sm(signed_mag_type x, signed_mag_type y);
      signed_mag_type r;
      r.mag = x.mag * y.mag;
      r.neg = (r.mag != 0) && (x.neg != y.neg);
      return r;
   endfunction

   function automatic signed_mag_type add_sm(signed_mag_type x, signed_mag_type y);
      signed_mag_type r;
      if (x.neg == y.neg) begin
         r.mag = x.mag + y.mag;
         r.neg = x.neg;
      end else if (x.mag >= y.mag) begin
         r.mag = x.mag - y.mag;
         r.neg = x.neg;
      end else begin
         r.mag = y.mag - x.mag;
         r.neg = y.neg;
      end
      if (r.mag == 0) r.neg = 1'b0;
      return r;
   endfunction

   function automatic signed_mag_type neg_sm(signed_mag_type x);
      if (x.mag != 0) x.neg = ~x.neg;
      return x;
   endfunction

   function automatic longint unsigned binary_gcd(longint unsigned u_in, longint unsigned v_in);
      longint unsigned u;
      longint unsigned v;
      longint unsigned t;
      int              shift;
      u     = u_in;
      v     = v_in;
      shift = 0;
      if (u == 0) return v;
      if (v == 0) return u;
      // common factors of two come out first
      while (((u | v) & 1) == 0) begin
         u >>= 1;
         v >>= 1;
         shift++;
      end
      while ((u & 1) == 0) u >>= 1;
      while (v != 0) begin
         while ((v & 1) == 0) v >>= 1;
         if (u > v) begin
            t = u;
            u = v;
            v = t;
         end
         v -= u;
      end
      return u << shift;
   endfunction

   function automatic fraction_result_type predict_fraction(cmd_type cmd,
         operand_type a_num, operand_type a_den, operand_type b_num, operand_type b_den);
      fraction_result_type res;
      signed_mag_type      an;
      signed_mag_type      ad;
      signed_mag_type      bn;
      signed_mag_type      bd;
      signed_mag_type      n;
      signed_mag_type      d;
      longint unsigned     g;
      longint unsigned     nm;
      longint unsigned     dm;
      an = field_value(a_num);
      ad = field_value(a_den);
      bn = field_value(b_num);
      bd = field_value(b_den);
      case (cmd)
         CMD_ADD: begin
            n = add_sm(mul_sm(an, bd), mul_sm(ad, bn));
            d = mul_sm(ad, bd);
         end
         CMD_SUB: begin
            n = add_sm(mul_sm(an, bd), neg_sm(mul_sm(ad, bn)));
            d = mul_sm(ad, bd);
         end
         CMD_MUL: begin
            n = mul_sm(an, bn);
            d = mul_sm(ad, bd);
         end
         CMD_DIV: begin
            n = mul_sm(an, bd);
            d = mul_sm(ad, bn);
         end
         default: begin
            // negate, and the unused codes behave the same
            n = neg_sm(an);
            d = ad;
         end
      endcase
      if (d.mag == 0) begin
         res.num      = '0;
         res.den      = '0;
         res.zero_den = 1'b1;
      end else if (n.mag == 0) begin
         res.num      = '0;
         res.den      = res_den_type'(1);
         res.zero_den = 1'b0;
      end else begin
         g  = binary_gcd(n.mag, d.mag);
         nm = n.mag / g;
         dm = d.mag / g;
         // sign goes on the numerator, denominator stays positive
         res.num      = (n.neg != d.neg) ? res_num_type'(64'd0 - nm) : res_num_type'(nm);
         res.den      = res_den_type'(dm);
         res.zero_den = 1'b0;
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------

   // one request transfer; the expected fraction is queued at the accepting edge
   task automatic send_request(cmd_type cmd, operand_type a_num, operand_type a_den,
                               operand_type b_num, operand_type b_den);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd   <= cmd;
      req_bus.a_num <= a_num;
      req_bus.a_den <= a_den;
      req_bus.b_num <= b_num;
      req_bus.b_den <= b_den;
      do
         @(posedge clock);
      while (!req_bus.ready);
      pending_results.push_back(predict_fraction(cmd, a_num, a_den, b_num, b_den));
      // drop valid so that a pause after this request sends nothing twice
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   task automatic wait_results_done();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // mix of extremes, small values with shared factors, powers of two and noise
   function automatic operand_type random_field(bit is_den);
      int          sel;
      int          k;
      operand_type v;
      sel = $urandom_range(99);
      if (sel < (is_den ? 3 : 8))
         v = '0;
      else if (sel < 13)
         v = {1'b1, {(OPERAND_WIDTH-1){1'b0}}};
      else if (sel < 18)
         v = {1'b0, {(OPERAND_WIDTH-1){1'b1}}};
      else if (sel < 50)
         v = operand_type'($urandom_range(32) - 16);
      else if (sel < 60) begin
         k = $urandom_range(OPERAND_WIDTH - 2);
         v = operand_type'(1) << k;
         if ($urandom_range(1)) v = -v;
      end else
         v = operand_type'($urandom);
      return v;
   endfunction

   // mostly the five operations, now and then an unused code
   function automatic cmd_type random_cmd();
      if ($urandom_range(99) < 92)
         return cmd_type'($urandom_range(4));
      return cmd_type'($urandom_range(7, 5));
   endfunction

   task automatic send_random_request();
      send_request(random_cmd(), random_field(1'b0), random_field(1'b1),
                   random_field(1'b0), random_field(1'b1));
   endtask

   // ---------------------------------------------------------------------
   // response side
   // ---------------------------------------------------------------------

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      fraction_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $error("response transfer with no request outstanding");
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.res_num !== want.num) begin
               $error("res_num: expected %0d, actual %0d",
                      $signed(want.num), $signed(rsp_bus.res_num));
               fail_count++;
            end
            if (rsp_bus.res_den !== want.den) begin
               $error("res_den: expected %0d, actual %0d", want.den, rsp_bus.res_den);
               fail_count++;
            end
            if (rsp_bus.zero_den !== want.zero_den) begin
               $error("zero_den: expected %0d, actual %0d", want.zero_den, rsp_bus.zero_den);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // every operation, field extremes and the special results
   task automatic test_directed();
      send_request(CMD_ADD, 1, 2, 1, 3);                  // 5/6
      send_request(CMD_SUB, 1, 2, 1, 2);                  // zero comes out as 0/1
      send_request(CMD_MUL, 3, 4, -2, 3);                 // -1/2
      send_request(CMD_DIV, 6, -4, 9, 2);                 // negative denominator normalised
      send_request(CMD_DIV, 1, 2, 0, 5);                  // divide by zero value
      send_request(CMD_ADD, 1, 0, 1, 3);                  // zero denominator in a
      send_request(CMD_MUL, 1, 3, 2, 0);                  // zero denominator in b
      send_request(CMD_NEG, -3, -4, 7, 9);                // both parts negative
      send_request(CMD_NEG, 0, -5, 0, 0);                 // zero numerator, negative den
      send_request(CMD_NEG, 5, 0, 1, 1);                  // negate with zero denominator
      send_request(CMD_NEG, -32768, -1, 0, 0);            // most negative numerator
      send_request(cmd_type'(5), 4, 6, 1, 1);             // unused codes act as negate
      send_request(cmd_type'(6), -10, 15, 3, 3);
      send_request(cmd_type'(7), 12, -18, -1, -1);
      send_request(CMD_ADD, -32768, -32768, 32767, -32768);
      send_request(CMD_ADD, -32768, 1, -32768, 1);        // largest negative sum
      send_request(CMD_SUB, 32767, 1, -32768, 1);
      send_request(CMD_MUL, -32768, 32767, -32768, 32767);
      send_request(CMD_DIV, -32768, 1, 1, -32768);        // 2^30 over 1
      send_request(CMD_ADD, 32767, 32767, 32767, 32767);
      send_request(CMD_SUB, 32767, -32768, 32767, -32767);
      send_request(CMD_MUL, 0, -32768, 32767, 32767);
      wait_results_done();
   endtask

   task automatic test_random_traffic(int count);
      repeat (count) send_random_request();
   endtask

   // long stretch with neither side idling
   task automatic test_back_to_back(int count);
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      repeat (count) send_random_request();
      req_idle_pct  = 6;
      rsp_stall_pct = 6;
   endtask

   // sender holds off until every outstanding response has come back
   task automatic test_drain_pause(int groups, int per_group);
      repeat (groups) begin
         repeat (per_group) send_random_request();
         wait_results_done();
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.cmd   = CMD_ADD;
      req_bus.a_num = '0;
      req_bus.a_den = '0;
      req_bus.b_num = '0;
      req_bus.b_den = '0;
      rsp_bus.ready = 1'b0;
      req_idle_pct  = 6;
      rsp_stall_pct = 6;
      fail_count    = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_traffic(700);
      test_back_to_back(250);
      test_drain_pause(10, 10);

      wait_results_done();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // about six times the slowest legal run
   initial begin
      #4_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* sim.f */
design/rau_pkg.sv
design/rau_req_if.sv
design/rau_rsp_if.sv
design/rau_gcd.sv
design/rau_div.sv
design/rational_arith_unit.sv
tb/sv/rational_arith_unit_test.sv
